/* hw/rtl/gmrd_pkg.sv */
package gmrd_pkg;

    localparam int unsigned MOD_W = 31;
    localparam int unsigned RES_W = 32;

    typedef struct packed {
        logic signed [RES_W-1:0] residue;
        logic [MOD_W-1:0]        modulus;
        logic                    end_of_system;
    } t_in_item;

    typedef struct packed {
        logic [MOD_W-1:0] digit;
        logic             digit_last;
        logic             overflow;
    } t_out_item;

    // Command from the sequencer to the shared modular unit.
    typedef struct packed {
        logic             start;
        logic             is_mul;
        logic [2*MOD_W:0] a;
        logic [MOD_W-1:0] b;
        logic [MOD_W-1:0] m;
    } t_mu_cmd;

endpackage

/* hw/rtl/gmrd_ram.sv */
module gmrd_ram #(
    parameter int unsigned WIDTH = 31,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_waddr,
    input  logic [WIDTH-1:0]                                i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    i_raddr,
    output logic [WIDTH-1:0]                                o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/gmrd_modunit.sv */
// Shared unit: computes (a * b) mod m when is_mul, else a mod m (b ignored).
// Product formed by shift-add, one multiplier bit per cycle, then reduced by
// restoring division one quotient bit per cycle.
module gmrd_modunit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gmrd_pkg::t_mu_cmd           i_cmd,
    output logic                        o_done,
    output logic [gmrd_pkg::MOD_W-1:0]  o_result
);

    localparam int unsigned W  = gmrd_pkg::MOD_W;
    localparam int unsigned PW = 2 * W + 1;
    localparam int unsigned CW = $clog2(PW + 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_RED  = 3'b100
    } t_state;

    t_state         r_state, n_state;
    logic [PW-1:0]  r_acc, n_acc;
    logic [PW-1:0]  r_mcand, n_mcand;
    logic [W-1:0]   r_mplier, n_mplier;
    logic [W-1:0]   r_m, n_m;
    logic [W:0]     r_rem, n_rem;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_done, n_done;
    logic [W+1:0]   w_trial;

    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_mcand  = r_mcand;
        n_mplier = r_mplier;
        n_m      = r_m;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        w_trial  = {r_rem, r_acc[PW-1]} - {2'b00, r_m};
        case (r_state)
            S_IDLE: begin
                if (i_cmd.start) begin
                    n_m   = i_cmd.m;
                    n_rem = '0;
                    if (i_cmd.is_mul) begin
                        n_acc    = '0;
                        n_mcand  = i_cmd.a;
                        n_mplier = i_cmd.b;
                        n_cnt    = CW'(W);
                        n_state  = S_MUL;
                    end else begin
                        n_acc   = i_cmd.a;
                        n_cnt   = CW'(PW);
                        n_state = S_RED;
                    end
                end
            end
            S_MUL: begin
                if (r_mplier[0]) begin
                    n_acc = r_acc + r_mcand;
                end
                n_mcand  = r_mcand << 1;
                n_mplier = r_mplier >> 1;
                n_cnt    = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(PW);
                    n_state = S_RED;
                end
            end
            S_RED: begin
                // One restoring step; a zero modulus never subtracts, so the remainder only shifts.
                if (!w_trial[W+1] && r_m != '0) begin
                    n_rem = w_trial[W:0];
                end else begin
                    n_rem = {r_rem[W-1:0], r_acc[PW-1]};
                end
                n_acc = r_acc << 1;
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_cnt   <= n_cnt;
        end
        r_acc    <= n_acc;
        r_mcand  <= n_mcand;
        r_mplier <= n_mplier;
        r_m      <= n_m;
        r_rem    <= n_rem;
    end

    assign o_done   = r_done;
    assign o_result = r_rem[W-1:0];

endmodule

/* hw/rtl/garner_mixed_radix_digits_unit.sv */
// The residue of a congruence is first reduced mod its modulus; for each earlier congruence
// of the system, the inverse of that modulus is formed as a power to modulus - 2 and the
// digit difference is folded in by a multiply. An overflow result is registered and shows
// in the cycle after its input is taken. Reductions and multiplies run on one shared
// shift-add/restoring unit; a new item is taken only when idle with the last result taken.
// Reset (synchronous, active low) empties the system; stored entries stay stale.
module garner_mixed_radix_digits_unit #(
    parameter int unsigned MAX_MODULI = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  gmrd_pkg::t_in_item   i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output gmrd_pkg::t_out_item  o_data
);

    localparam int unsigned W  = gmrd_pkg::MOD_W;
    localparam int unsigned AW = (MAX_MODULI > 1) ? $clog2(MAX_MODULI) : 1;
    localparam int unsigned NW = $clog2(MAX_MODULI + 1);
    localparam int unsigned PW = 2 * W + 1;
    localparam int unsigned EW = $clog2(W + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RED   = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_XJ    = 10'b0000001000,
        S_PJ    = 10'b0000010000,
        S_EXP   = 10'b0000100000,
        S_SQR   = 10'b0001000000,
        S_DIFF  = 10'b0010000000,
        S_FOLD  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    t_state              r_state, n_state;
    logic [NW-1:0]       r_count, n_count;
    logic [NW-1:0]       r_j, n_j;
    logic [W-1:0]        r_m, n_m;
    logic [W-1:0]        r_exp, n_exp;
    logic [EW-1:0]       r_bit, n_bit;
    logic [W-1:0]        r_d, n_d;
    logic [W-1:0]        r_acc, n_acc;
    logic [W-1:0]        r_base, n_base;
    logic [W-1:0]        r_xj, n_xj;
    logic                r_last, n_last;
    logic                r_wait, n_wait;
    logic                r_ovalid, n_ovalid;
    gmrd_pkg::t_out_item r_out, n_out;
    gmrd_pkg::t_mu_cmd   w_cmd;
    logic                w_done;
    logic [W-1:0]        w_res;
    logic [W-1:0]        w_mod_rd, w_dig_rd;
    logic                w_we;
    logic [AW-1:0]       w_raddr, w_waddr;
    logic [PW-1:0]       w_shift_res;
    logic [W:0]          w_sum;

    gmrd_modunit u_mu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_done   (w_done),
        .o_result (w_res)
    );

    gmrd_ram #(.WIDTH(W), .DEPTH(MAX_MODULI)) u_mod_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_m),
        .i_raddr(w_raddr), .o_rdata(w_mod_rd)
    );

    gmrd_ram #(.WIDTH(W), .DEPTH(MAX_MODULI)) u_dig_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(r_d),
        .i_raddr(w_raddr), .o_rdata(w_dig_rd)
    );

    assign w_raddr = r_j[AW-1:0];
    assign w_waddr = r_count[AW-1:0];
    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // A negative residue is offset by 2^31 * 2m, which is a multiple of m.
    assign w_shift_res = i_data.residue[W]
        ? PW'($signed(i_data.residue)) + ({{(PW-W){1'b0}}, i_data.modulus} << (W + 1))
        : PW'($unsigned(i_data.residue));
    assign w_sum = {1'b0, r_d} + {1'b0, r_m} - {1'b0, r_xj};

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_j      = r_j;
        n_m      = r_m;
        n_exp    = r_exp;
        n_bit    = r_bit;
        n_d      = r_d;
        n_acc    = r_acc;
        n_base   = r_base;
        n_xj     = r_xj;
        n_last   = r_last;
        n_wait   = r_wait;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        w_we     = 1'b0;
        w_cmd    = '{start: 1'b0, is_mul: 1'b0, a: '0, b: '0, m: r_m};

        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_m    = i_data.modulus;
                    n_last = i_data.end_of_system;
                    n_exp  = (i_data.modulus >= W'(2)) ? i_data.modulus - W'(2) : '0;
                    n_j    = '0;
                    if (r_count >= NW'(MAX_MODULI)) begin
                        n_out    = '{digit: '0, digit_last: i_data.end_of_system,
                                     overflow: 1'b1};
                        n_ovalid = 1'b1;
                        if (i_data.end_of_system) begin
                            n_count = '0;
                        end
                    end else begin
                        w_cmd = '{start: 1'b1, is_mul: 1'b0, a: w_shift_res, b: '0,
                                  m: i_data.modulus};
                        n_state = S_RED;
                    end
                end
            end
            S_RED: begin
                if (w_done) begin
                    // A zero modulus always yields a zero digit.
                    n_d     = (r_m == '0) ? '0 : w_res;
                    n_state = (r_j == r_count) ? S_OUT : S_RD;
                end
            end
            S_RD: begin
                n_state = S_XJ;
            end
            S_XJ: begin
                // Memory data for entry j is valid here.
                w_cmd  = '{start: 1'b1, is_mul: 1'b0, a: PW'(w_dig_rd), b: '0, m: r_m};
                n_base = w_mod_rd;
                n_wait = 1'b1;
                if (w_done) begin
                    n_xj = w_res;
                end
                n_state = S_PJ;
            end
            S_PJ: begin
                if (w_done && r_wait) begin
                    n_xj   = w_res;
                    n_wait = 1'b0;
                    w_cmd  = '{start: 1'b1, is_mul: 1'b0, a: PW'(r_base), b: '0, m: r_m};
                end else if (w_done) begin
                    n_base  = w_res;
                    n_acc   = (r_m == W'(1)) ? '0 : W'(1);
                    n_bit   = '0;
                    n_state = S_EXP;
                end
            end
            S_EXP: begin
                // acc = acc*base when exponent bit set; skipped otherwise.
                if (!r_wait) begin
                    if (r_exp[r_bit[EW-1:0]]) begin
                        w_cmd  = '{start: 1'b1, is_mul: 1'b1, a: PW'(r_acc), b: r_base,
                                   m: r_m};
                        n_wait = 1'b1;
                    end else begin
                        n_state = S_SQR;
                    end
                end else if (w_done) begin
                    n_acc   = w_res;
                    n_wait  = 1'b0;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                if (!r_wait) begin
                    if (r_bit == EW'(W - 1)) begin
                        n_state = S_DIFF;
                    end else begin
                        w_cmd  = '{start: 1'b1, is_mul: 1'b1, a: PW'(r_base), b: r_base,
                                   m: r_m};
                        n_wait = 1'b1;
                    end
                end else if (w_done) begin
                    n_base  = w_res;
                    n_wait  = 1'b0;
                    n_bit   = r_bit + 1'b1;
                    n_state = S_EXP;
                end
            end
            S_DIFF: begin
                n_d = (w_sum >= {1'b0, r_m}) ? W'(w_sum - {1'b0, r_m}) : w_sum[W-1:0];
                w_cmd = '{start: 1'b1, is_mul: 1'b1, a: PW'(r_acc), b: n_d, m: r_m};
                n_state = S_FOLD;
            end
            S_FOLD: begin
                if (w_done) begin
                    n_d     = (r_m == '0) ? '0 : w_res;
                    n_j     = r_j + 1'b1;
                    n_state = (r_j + 1'b1 == r_count) ? S_OUT : S_RD;
                end
            end
            S_OUT: begin
                if (!r_ovalid) begin
                    w_we     = 1'b1;
                    n_out    = '{digit: r_d, digit_last: r_last, overflow: 1'b0};
                    n_ovalid = 1'b1;
                    n_count  = r_last ? '0 : r_count + 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_wait   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
            r_wait   <= n_wait;
        end
        r_j    <= n_j;
        r_m    <= n_m;
        r_exp  <= n_exp;
        r_bit  <= n_bit;
        r_d    <= n_d;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_xj   <= n_xj;
        r_last <= n_last;
        r_out  <= n_out;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(MAX_MODULI))
        else $error("congruence count beyond capacity");

    a_digit_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_we && r_m != '0) |-> (r_d < r_m))
        else $error("stored digit not reduced");

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("ready while busy");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid) && o_data.digit_last) |-> (r_count == '0))
        else $error("count not cleared after last");

endmodule

/* test/tb_garner_mixed_radix_digits_unit.sv */
module tb_garner_mixed_radix_digits_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY    = 16;
    localparam int unsigned N_RANDOM    = 120;
    localparam longint     CYCLE_LIMIT = 30_000_000;
    localparam int unsigned QUIET_FIRST = 60;
    localparam int unsigned QUIET_LAST  = 90;
    localparam int unsigned HOLD_AT     = 30;
    localparam int unsigned HOLD_CYCLES = 3000;

    typedef struct {
        gmrd_pkg::t_in_item  item;
        bit                  typed;
        gmrd_pkg::t_out_item digit_typed;
    } t_stim_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_ready;
    gmrd_pkg::t_in_item  i_data;
    logic                o_valid;
    logic                i_ready;
    gmrd_pkg::t_out_item o_data;

    garner_mixed_radix_digits_unit #(
        .MAX_MODULI(CAPACITY)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Predictor state: the moduli and digits of the open system.
    logic [gmrd_pkg::MOD_W-1:0] sys_moduli [CAPACITY];
    logic [gmrd_pkg::MOD_W-1:0] sys_digits [CAPACITY];
    int unsigned                sys_count;

    t_stim_row           stim_rows [$];
    t_stim_row           typed_rows [$];
    gmrd_pkg::t_out_item pending_digits [$];
    int unsigned         n_errors;
    int unsigned         n_accepted;
    longint              n_cycles;
    bit                  hold_off;

    function automatic longint unsigned fermat_pow(longint unsigned base, longint unsigned e,
                                                   longint unsigned m);
        longint unsigned acc;
        acc  = 1 % m;
        base = base % m;
        while (e != 0) begin
            if (e[0]) begin
                acc = (acc % m) * (base % m) % m;
            end
            base = (base % m) * (base % m) % m;
            e    = e >> 1;
        end
        return acc;
    endfunction

    function automatic gmrd_pkg::t_out_item garner_step(gmrd_pkg::t_in_item it);
        gmrd_pkg::t_out_item r;
        longint unsigned m;
        longint unsigned d;
        longint unsigned e;
        longint unsigned inv;
        longint unsigned xj;
        longint unsigned diff;
        longint          sm;
        r = '0;
        r.digit_last = it.end_of_system;
        if (sys_count >= CAPACITY) begin
            sys_count  = CAPACITY;
            r.overflow = 1'b1;
        end else begin
            m = it.modulus;
            d = 0;
            if (m != 0) begin
                sm = longint'(m);
                d  = longint'(((longint'(it.residue) % sm) + sm) % sm);
                e  = (m >= 2) ? m - 2 : 0;
                for (int unsigned j = 0; j < sys_count; j++) begin
                    inv  = fermat_pow(longint'(sys_moduli[j]), e, m);
                    xj   = longint'(sys_digits[j]) % m;
                    diff = (d + m - xj) % m;
                    d    = (inv % m) * (diff % m) % m;
                end
            end
            r.digit               = d[gmrd_pkg::MOD_W-1:0];
            sys_moduli[sys_count] = it.modulus;
            sys_digits[sys_count] = d[gmrd_pkg::MOD_W-1:0];
            sys_count++;
        end
        if (it.end_of_system) begin
            sys_count = 0;
        end
        return r;
    endfunction

    function automatic void add_row(logic signed [gmrd_pkg::RES_W-1:0] residue,
                                    logic [gmrd_pkg::MOD_W-1:0] modulus,
                                    logic eos, bit typed = 1'b0,
                                    logic [gmrd_pkg::MOD_W-1:0] digit = '0,
                                    logic ovf = 1'b0);
        t_stim_row row;
        row.item.residue       = residue;
        row.item.modulus       = modulus;
        row.item.end_of_system = eos;
        row.typed              = typed;
        row.digit_typed.digit      = digit;
        row.digit_typed.digit_last = eos;
        row.digit_typed.overflow   = ovf;
        stim_rows.push_back(row);
    endfunction

    function automatic logic [gmrd_pkg::MOD_W-1:0] random_modulus();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) begin
            return gmrd_pkg::MOD_W'($urandom_range(1));
        end else if (pick < 40) begin
            return gmrd_pkg::MOD_W'($urandom_range(1000, 2));
        end
        return gmrd_pkg::MOD_W'($urandom());
    endfunction

    function automatic void build_stimulus();
        int unsigned n_random;
        int unsigned sys_len;
        // Single-congruence systems at the extremes of the fields.
        add_row(32'sd0, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'd0);
        add_row(-32'sd1, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'h7FFF_FFFE);
        add_row(32'sh7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b1, 31'd0);
        add_row(32'sh8000_0000, 31'd2, 1'b1, 1'b1, 31'd0);
        add_row(32'sd12345, 31'd0, 1'b1, 1'b1, 31'd0);
        add_row(-32'sd77, 31'd1, 1'b1, 1'b1, 31'd0);
        // A shared modulus, then a full system that runs past capacity.
        add_row(32'sd5, 31'd7, 1'b0);
        add_row(32'sd3, 31'd7, 1'b1);
        for (int unsigned k = 0; k < CAPACITY; k++) begin
            add_row(32'($urandom()), gmrd_pkg::MOD_W'($urandom()), 1'b0);
        end
        add_row(32'sd9, 31'd13, 1'b0, 1'b1, 31'd0, 1'b1);
        add_row(-32'sd9, 31'd17, 1'b1, 1'b1, 31'd0, 1'b1);

        // Mostly short well-formed systems with random content.
        n_random = 0;
        while (n_random < N_RANDOM) begin
            sys_len = ($urandom_range(9) == 0) ? $urandom_range(6, 4) : $urandom_range(3, 1);
            for (int unsigned k = 0; k < sys_len; k++) begin
                add_row(32'($urandom()), random_modulus(), 1'(k == sys_len - 1));
                n_random++;
            end
        end
    endfunction

    function automatic bit quiet_window();
        return (n_accepted >= QUIET_FIRST) && (n_accepted < QUIET_LAST);
    endfunction

    // Expected digits are queued when the block takes a transaction.
    always @(posedge i_clk) begin
        t_stim_row row;
        gmrd_pkg::t_out_item exp_digit;
        if (i_rst_n && i_valid && o_ready) begin
            exp_digit = garner_step(i_data);
            if (typed_rows.size() > 0) begin
                row = typed_rows.pop_front();
                if (row.typed) begin
                    exp_digit = row.digit_typed;
                end
            end
            pending_digits.push_back(exp_digit);
            n_accepted++;
        end
    end

    always @(posedge i_clk) begin
        gmrd_pkg::t_out_item exp_digit;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_digits.size() == 0) begin
                $display("%0t: unexpected digit %0d last %0b overflow %0b", $realtime,
                         o_data.digit, o_data.digit_last, o_data.overflow);
                n_errors++;
            end else begin
                exp_digit = pending_digits.pop_front();
                if (o_data.digit !== exp_digit.digit) begin
                    $display("%0t: digit expected %0d actual %0d", $realtime,
                             exp_digit.digit, o_data.digit);
                    n_errors++;
                end
                if (o_data.digit_last !== exp_digit.digit_last) begin
                    $display("%0t: digit_last expected %0b actual %0b", $realtime,
                             exp_digit.digit_last, o_data.digit_last);
                    n_errors++;
                end
                if (o_data.overflow !== exp_digit.overflow) begin
                    $display("%0t: overflow expected %0b actual %0b", $realtime,
                             exp_digit.overflow, o_data.overflow);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off) begin
            i_ready <= 1'b0;
        end else if (quiet_window()) begin
            i_ready <= 1'b1;
        end else begin
            i_ready <= ($urandom_range(99) >= 18);
        end
    end

    // The receiver stalls for a long stretch while the sender keeps offering.
    initial begin
        hold_off = 1'b0;
        wait (n_accepted >= HOLD_AT);
        @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        t_stim_row row;
        n_errors   = 0;
        n_accepted = 0;
        n_cycles   = 0;
        sys_count  = 0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        build_stimulus();
        typed_rows = stim_rows;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[idx]) begin
            row = stim_rows[idx];
            if (!quiet_window() && $urandom_range(99) < 18) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(4, 1)) @(posedge i_clk);
            end
            i_valid <= 1'b1;
            i_data  <= row.item;
            @(posedge i_clk);
            while (!o_ready) begin
                @(posedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // Every transaction must be taken and every digit must come back.
        while (n_accepted < stim_rows.size() || pending_digits.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (200) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/gmrd_pkg.sv
hw/rtl/gmrd_ram.sv
hw/rtl/gmrd_modunit.sv
hw/rtl/garner_mixed_radix_digits_unit.sv
test/tb_garner_mixed_radix_digits_unit.sv
